/* hdl/ldp_pkg.sv */
// Shared constants and inter-module structs for the log-domain dot product.
// No dependencies; imported by ldp_seq and log_domain_dot_product.
`timescale 1ns / 1ps
`default_nettype none

package ldp_pkg;

  localparam int unsigned DEF_MAX_TERMS = 64;
  localparam int unsigned DEF_FRAC_BITS = 16;

  // Minimum code stands for minus infinity, maximum code for plus infinity.
  localparam logic [31:0] CODE_MIN = 32'h8000_0000;
  localparam logic [31:0] CODE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] LN2_Q32  = 32'hB172_17F8;

  localparam int unsigned   ACC_W   = 40;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  typedef struct packed {
    logic        start;
    logic [31:0] max_sum;
  } ldp_ctl_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] result;
  } ldp_rsp_t;

endpackage

`default_nettype wire

/* hdl/ldp_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ldp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/ldp_seq.sv */
// Sequencer for the exponent pass and the final log1p, built around one
// shared multiplier with a registered product. Depends on ldp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldp_seq #(
  parameter int unsigned MAX_TERMS = ldp_pkg::DEF_MAX_TERMS,
  parameter int unsigned FRAC_BITS = ldp_pkg::DEF_FRAC_BITS,
  localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ldp_pkg::ldp_ctl_t ctl_i,
  input  logic [IDX_W-1:0]  max_idx_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic              ram_re_o,
  output logic [IDX_W-1:0]  ram_raddr_o,
  input  logic [31:0]       ram_rdata_i,
  output ldp_pkg::ldp_rsp_t rsp_o
);

  import ldp_pkg::*;

  localparam int unsigned SH = 32 - FRAC_BITS;
  localparam logic [32:0] FAR_LIM = 33'(64) << FRAC_BITS;
  localparam logic [40:0] RND = 41'(1) << (31 - FRAC_BITS);
  localparam logic [40:0] ONE_Y = 41'(1) << FRAC_BITS;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_RD    = 18'h00002,
    ST_DIFF  = 18'h00004,
    ST_KDIV  = 18'h00008,
    ST_TMUL  = 18'h00010,
    ST_TDIV  = 18'h00020,
    ST_TCOR  = 18'h00040,
    ST_EXPR  = 18'h00080,
    ST_LINIT = 18'h00100,
    ST_LNRM  = 18'h00200,
    ST_LDIV  = 18'h00400,
    ST_LZ2   = 18'h00800,
    ST_LZ2W  = 18'h01000,
    ST_LPM   = 18'h02000,
    ST_LPD   = 18'h04000,
    ST_LPC   = 18'h08000,
    ST_LK    = 18'h10000,
    ST_LFIN  = 18'h20000
  } seq_state_e;

  // floor(2^32 / n), capped to 32 bits; used for exact division by n
  function automatic logic [31:0] recip_f(input logic [4:0] n);
    logic [31:0] r;
    unique case (n)
      5'd1:    r = 32'hFFFF_FFFF;
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd15:   r = 32'h1111_1111;
      5'd17:   r = 32'h0F0F_0F0F;
      5'd19:   r = 32'h0D79_435E;
      5'd21:   r = 32'h0C30_C30C;
      5'd23:   r = 32'h0B21_642C;
      5'd25:   r = 32'h0A3D_70A3;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  seq_state_e        state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              sat_q, sat_d;
  logic              done_q, done_d;
  logic [31:0]       res_q, res_d;
  logic [38:0]       krem_q, krem_d;
  logic [2:0]        kb_q, kb_d;
  logic [6:0]        k_q, k_d;
  logic [32:0]       term_q, term_d;
  logic [33:0]       sum_q, sum_d;
  logic [4:0]        n_q, n_d;
  logic [31:0]       p_q, p_d;
  logic [40:0]       w_q, w_d;
  logic [5:0]        msb_q, msb_d;
  logic [5:0]        kl_q, kl_d;
  logic [33:0]       den_q, den_d;
  logic [34:0]       drem_q, drem_d;
  logic [4:0]        dc_q, dc_d;
  logic [31:0]       z_q, z_d;
  logic [31:0]       z2_q, z2_d;
  logic [32:0]       lsum_q, lsum_d;
  logic [64:0]       prod_q;
  logic [32:0]       mul_a;
  logic [31:0]       mul_b;

  // correction after the reciprocal multiply
  logic [31:0] q0, qfix;
  logic [36:0] qn, crem;
  // exponent path
  logic [32:0] diff;
  logic [38:0] ln2s;
  logic        kge;
  logic [33:0] val;
  logic [63:0] e_full;
  logic [40:0] acc_sum;
  // log path
  logic [34:0] r2;
  logic        dge;
  logic [39:0] lnv;
  logic [40:0] lr;
  logic [33:0] resw;

  always_comb begin
    q0   = prod_q[63:32];
    qn   = 37'(q0) * 37'(n_q);
    crem = 37'(p_q) - qn;
    qfix = q0 + 32'(crem >= 37'(n_q));

    diff = {ctl_i.max_sum[31], ctl_i.max_sum} - {ram_rdata_i[31], ram_rdata_i};
    ln2s = 39'(LN2_Q32) << kb_q;
    kge  = krem_q >= ln2s;

    val     = (k_q < 7'd64) ? (sum_q >> k_q[5:0]) : '0;
    e_full  = (64'(val) + 64'(RND)) >> SH;
    acc_sum = 41'(acc_q) + e_full[40:0];

    r2  = {drem_q[33:0], 1'b0};
    dge = r2 >= 35'(den_q);

    lnv  = 40'(prod_q[37:0]) + {6'b0, lsum_q, 1'b0};
    lr   = (41'(lnv) + RND) >> SH;
    resw = {{2{ctl_i.max_sum[31]}}, ctl_i.max_sum} + {2'b0, lr[31:0]};
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    sat_d   = sat_q;
    done_d  = 1'b0;
    res_d   = res_q;
    krem_d  = krem_q;
    kb_d    = kb_q;
    k_d     = k_q;
    term_d  = term_q;
    sum_d   = sum_q;
    n_d     = n_q;
    p_d     = p_q;
    w_d     = w_q;
    msb_d   = msb_q;
    kl_d    = kl_q;
    den_d   = den_q;
    drem_d  = drem_q;
    dc_d    = dc_q;
    z_d     = z_q;
    z2_d    = z2_q;
    lsum_d  = lsum_q;
    mul_a   = '0;
    mul_b   = '0;
    ram_re_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          idx_d   = '0;
          acc_d   = '0;
          sat_d   = 1'b0;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (idx_q == count_i) begin
          state_d = ST_LINIT;
        end else if (idx_q == CNT_W'(max_idx_i)) begin
          idx_d = idx_q + 1'b1;
        end else begin
          ram_re_o = 1'b1;
          idx_d    = idx_q + 1'b1;
          state_d  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        // drop far terms: they add zero
        if (diff >= FAR_LIM) begin
          state_d = ST_RD;
        end else begin
          krem_d  = 39'(diff) << SH;
          kb_d    = 3'd6;
          k_d     = '0;
          state_d = ST_KDIV;
        end
      end
      ST_KDIV: begin
        if (kge) begin
          krem_d = krem_q - ln2s;
        end
        k_d  = {k_q[5:0], kge};
        kb_d = kb_q - 1'b1;
        if (kb_q == 3'd0) begin
          term_d  = 33'h1_0000_0000;
          sum_d   = 34'h1_0000_0000;
          n_d     = 5'd1;
          state_d = ST_TMUL;
        end
      end
      ST_TMUL: begin
        mul_a   = term_q;
        mul_b   = krem_q[31:0];
        state_d = ST_TDIV;
      end
      ST_TDIV: begin
        p_d     = prod_q[63:32];
        mul_a   = 33'(prod_q[63:32]);
        mul_b   = recip_f(n_q);
        state_d = ST_TCOR;
      end
      ST_TCOR: begin
        term_d = 33'(qfix);
        sum_d  = n_q[0] ? (sum_q - 34'(qfix)) : (sum_q + 34'(qfix));
        if (n_q == 5'd12) begin
          state_d = ST_EXPR;
        end else begin
          n_d     = n_q + 1'b1;
          state_d = ST_TMUL;
        end
      end
      ST_EXPR: begin
        if (acc_sum > 41'(ACC_MAX)) begin
          acc_d = ACC_MAX;
          sat_d = 1'b1;
        end else begin
          acc_d = acc_sum[ACC_W-1:0];
        end
        state_d = ST_RD;
      end
      ST_LINIT: begin
        w_d     = 41'(acc_q) + ONE_Y;
        msb_d   = 6'd40;
        state_d = ST_LNRM;
      end
      ST_LNRM: begin
        if (w_q[40]) begin
          den_d   = 34'(w_q[40:8]) + 34'h1_0000_0000;
          drem_d  = 35'(w_q[39:8]);
          kl_d    = msb_q - 6'(FRAC_BITS);
          dc_d    = '0;
          z_d     = '0;
          state_d = ST_LDIV;
        end else begin
          w_d   = {w_q[39:0], 1'b0};
          msb_d = msb_q - 1'b1;
        end
      end
      ST_LDIV: begin
        drem_d = dge ? (r2 - 35'(den_q)) : r2;
        z_d    = {z_q[30:0], dge};
        dc_d   = dc_q + 1'b1;
        if (dc_q == 5'd31) begin
          state_d = ST_LZ2;
        end
      end
      ST_LZ2: begin
        mul_a   = 33'(z_q);
        mul_b   = z_q;
        state_d = ST_LZ2W;
      end
      ST_LZ2W: begin
        z2_d    = prod_q[63:32];
        p_d     = z_q;
        lsum_d  = 33'(z_q);
        n_d     = 5'd3;
        state_d = ST_LPM;
      end
      ST_LPM: begin
        mul_a   = 33'(p_q);
        mul_b   = z2_q;
        state_d = ST_LPD;
      end
      ST_LPD: begin
        p_d     = prod_q[63:32];
        mul_a   = 33'(prod_q[63:32]);
        mul_b   = recip_f(n_q);
        state_d = ST_LPC;
      end
      ST_LPC: begin
        lsum_d = lsum_q + 33'(qfix);
        if (n_q == 5'd25) begin
          state_d = ST_LK;
        end else begin
          n_d     = n_q + 5'd2;
          state_d = ST_LPM;
        end
      end
      ST_LK: begin
        mul_a   = 33'(kl_q);
        mul_b   = LN2_Q32;
        state_d = ST_LFIN;
      end
      ST_LFIN: begin
        if ($signed(resw) > $signed({2'b00, CODE_MAX})) begin
          res_d = CODE_MAX;
          sat_d = 1'b1;
        end else begin
          res_d = resw[31:0];
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ram_raddr_o = idx_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      acc_q   <= '0;
      sat_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      sat_q   <= sat_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    krem_q <= krem_d;
    kb_q   <= kb_d;
    k_q    <= k_d;
    term_q <= term_d;
    sum_q  <= sum_d;
    n_q    <= n_d;
    p_q    <= p_d;
    w_q    <= w_d;
    msb_q  <= msb_d;
    kl_q   <= kl_d;
    den_q  <= den_d;
    drem_q <= drem_d;
    dc_q   <= dc_d;
    z_q    <= z_d;
    z2_q   <= z2_d;
    lsum_q <= lsum_d;
    prod_q <= 65'(mul_a) * 65'(mul_b);
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.sat    = sat_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire

/* hdl/log_domain_dot_product.sv */
// Log-domain dot product: term loading, running maximum, output register.
// Depends on ldp_pkg, ldp_ram and ldp_seq.
//
// The block takes one pair of Q15.16 log values per word, stores their
// saturated sum and tracks the largest sum, then on the word marked last
// returns max + log1p(sum of exp(s - max)) over the other stored sums.
// The minimum code means minus infinity; an infinite maximum is returned
// as is. A non-last word is taken without a stall. After a last word the
// block stalls its input while one shared multiplier and two restoring
// dividers work through the vector: each stored term gets an ln2 range
// reduction and a 12-step exp series of multiply-and-divide steps, a term
// 64 or more below the maximum is skipped, and the maximum itself is
// skipped too. The final log1p normalizes, divides and sums a series.
// Words beyond MAX_TERMS are dropped and flagged. The result waits in an
// output register while the next vector is loaded.
`timescale 1ns / 1ps
`default_nettype none

module log_domain_dot_product #(
  parameter int unsigned MAX_TERMS = ldp_pkg::DEF_MAX_TERMS,
  parameter int unsigned FRAC_BITS = ldp_pkg::DEF_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] log_a_i,
  input  logic [31:0] log_b_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] log_result_o,
  output logic        saturated_o
);

  import ldp_pkg::*;

  localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_CHK  = 4'b0010,
    S_WAIT = 4'b0100,
    S_HOLD = 4'b1000
  } top_state_e;

  top_state_e       state_q, state_d;
  logic [31:0]      max_q, max_d;
  logic [IDX_W-1:0] max_idx_q, max_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             sat_q, sat_d;
  logic [31:0]      pend_res_q, pend_res_d;
  logic             pend_sat_q, pend_sat_d;
  logic             out_valid_q;
  logic [31:0]      out_res_q;
  logic             out_sat_q;

  logic        in_acc, out_free, room, gt, max_inf;
  logic [32:0] sum33;
  logic [31:0] s;
  logic        s_sat;
  logic        ram_we;
  logic        ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0] ram_rdata;
  ldp_ctl_t    seq_ctl;
  ldp_rsp_t    seq_rsp;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Saturating sum of the two logs; minus infinity absorbs without a flag.
  always_comb begin
    sum33 = {log_a_i[31], log_a_i} + {log_b_i[31], log_b_i};
    s_sat = 1'b0;
    if (log_a_i == CODE_MIN || log_b_i == CODE_MIN) begin
      s = CODE_MIN;
    end else if (sum33[32] != sum33[31]) begin
      s     = sum33[32] ? CODE_MIN : CODE_MAX;
      s_sat = 1'b1;
    end else if (sum33[31:0] == CODE_MIN) begin
      s     = CODE_MIN;
      s_sat = 1'b1;
    end else begin
      s = sum33[31:0];
    end
  end

  assign room    = count_q < CNT_W'(MAX_TERMS);
  // strict compare: the first of equal maxima keeps its place
  assign gt      = $signed(s) > $signed(max_q);
  assign max_inf = (max_q == CODE_MIN) || (max_q == CODE_MAX);
  assign ram_we  = in_acc && room;

  always_comb begin
    state_d    = state_q;
    max_d      = max_q;
    max_idx_d  = max_idx_q;
    count_d    = count_q;
    sat_d      = sat_q;
    pend_res_d = pend_res_q;
    pend_sat_d = pend_sat_q;
    seq_ctl.start   = 1'b0;
    seq_ctl.max_sum = max_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (s_sat) begin
            sat_d = 1'b1;
          end
          if (room) begin
            if (gt) begin
              max_d     = s;
              max_idx_d = count_q[IDX_W-1:0];
            end
            count_d = count_q + 1'b1;
          end else begin
            // drop the word and flag it
            sat_d = 1'b1;
          end
          if (last_i) begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (max_inf) begin
          pend_res_d = max_q;
          pend_sat_d = sat_q;
          state_d    = S_HOLD;
        end else begin
          seq_ctl.start = 1'b1;
          state_d       = S_WAIT;
        end
      end
      S_WAIT: begin
        if (seq_rsp.done) begin
          pend_res_d = seq_rsp.result;
          pend_sat_d = sat_q || seq_rsp.sat;
          state_d    = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          // hand the result over and clear the vector state
          max_d     = CODE_MIN;
          max_idx_d = '0;
          count_d   = '0;
          sat_d     = 1'b0;
          state_d   = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      max_q       <= CODE_MIN;
      max_idx_q   <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      max_q     <= max_d;
      max_idx_q <= max_idx_d;
      count_q   <= count_d;
      sat_q     <= sat_d;
      if (state_q == S_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_res_q <= pend_res_d;
    pend_sat_q <= pend_sat_d;
    if (state_q == S_HOLD && out_free) begin
      out_res_q <= pend_res_q;
      out_sat_q <= pend_sat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign log_result_o = out_res_q;
  assign saturated_o  = out_sat_q;

  ldp_ram #(
    .WIDTH (32),
    .DEPTH (MAX_TERMS)
  ) u_terms (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (s),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ldp_seq #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (seq_ctl),
    .max_idx_i   (max_idx_q),
    .count_i     (count_q),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rsp_o       (seq_rsp)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_TERMS))
    else $error("term count beyond capacity");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_rsp.done |-> (state_q == S_WAIT))
    else $error("sequencer finished outside of a pass");

  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_HOLD))
    else $error("result word appeared without a finished vector");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD && out_free) |=> (count_q == '0 && max_q == CODE_MIN))
    else $error("vector state not cleared after hand-over");

  a_chk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (count_q != '0))
    else $error("pass started on an empty vector");
`endif

endmodule

`default_nettype wire
